// File: src/gda_pkg.sv
package gda_pkg;

  localparam int unsigned YEAR_W = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W = 5;
  localparam int unsigned AMT_W = 16;
  localparam int unsigned DOY_W = 9;
  localparam int unsigned WD_W = 3;
  localparam int unsigned YMOD_W = 9;
  localparam int unsigned OPND_W = 17;
  localparam int unsigned RECIP_W = 16;
  localparam int unsigned PROD_W = OPND_W + RECIP_W;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [YMOD_W-1:0] YMOD_MAX = 9'd399;

  typedef enum logic {
    OP_ADD_DAYS   = 1'b0,
    OP_ADD_MONTHS = 1'b1
  } op_e;

  // constant divisors served by the shared reciprocal unit
  typedef enum logic [1:0] {
    DIV_7,
    DIV_12,
    DIV_100,
    DIV_400
  } div_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_DMOD_MUL,
    ST_DMOD_SUB,
    ST_WALK,
    ST_MDIV_MUL,
    ST_MDIV_SUB,
    ST_YMOD_MUL,
    ST_YMOD_SUB,
    ST_CENT_MUL,
    ST_CENT_SUM,
    ST_WD_MUL,
    ST_WD_SUB,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DMOD_MUL,
    DP_DMOD_SUB,
    DP_WALK,
    DP_MDIV_MUL,
    DP_MDIV_SUB,
    DP_YMOD_MUL,
    DP_YMOD_SUB,
    DP_CENT_MUL,
    DP_CENT_SUM,
    DP_WD_MUL,
    DP_WD_SUB
  } step_e;

  typedef struct packed {
    step_e step;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic months;
    logic walk_done;
  } sts_t;

  // reciprocals, exact for operands below 2^17 (7, 100, 400: below 43690)
  function automatic logic [RECIP_W-1:0] div_recip(input div_e sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      DIV_7:   r = 16'd37450;
      DIV_12:  r = 16'd43691;
      DIV_100: r = 16'd5243;
      DIV_400: r = 16'd41944;
      default: r = 16'd41944;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] div_shift(input div_e sel);
    logic [4:0] s;
    case (sel)
      DIV_7:   s = 5'd18;
      DIV_12:  s = 5'd19;
      DIV_100: s = 5'd19;
      DIV_400: s = 5'd24;
      default: s = 5'd24;
    endcase
    return s;
  endfunction

  // leap year from year mod 400
  function automatic logic leap_of_mod(input logic [YMOD_W-1:0] ym);
    return (ym[1:0] == 2'b00) && (ym != 9'd100) && (ym != 9'd200) && (ym != 9'd300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] l;
    case (m)
      4'd2:    l = leap ? 5'd29 : 5'd28;
      4'd4:    l = 5'd30;
      4'd6:    l = 5'd30;
      4'd9:    l = 5'd30;
      4'd11:   l = 5'd30;
      default: l = 5'd31;
    endcase
    return l;
  endfunction

  // days before the first of month m in a common year
  function automatic logic [DOY_W-1:0] month_cum(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] c;
    case (m)
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd243;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      default: c = 9'd0;
    endcase
    return c;
  endfunction

  // 2m + 3(m+1)/5 with Jan/Feb taken as months 13/14
  function automatic logic [5:0] wd_month_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    case (m)
      4'd1:    t = 6'd34;
      4'd2:    t = 6'd37;
      4'd3:    t = 6'd8;
      4'd4:    t = 6'd11;
      4'd5:    t = 6'd13;
      4'd6:    t = 6'd16;
      4'd7:    t = 6'd18;
      4'd8:    t = 6'd21;
      4'd9:    t = 6'd24;
      4'd10:   t = 6'd26;
      4'd11:   t = 6'd29;
      4'd12:   t = 6'd31;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

// File: src/gregorian_date_arithmetic_core.sv
// Channel  Direction  Handshake               Beat contents
// in       sink       in_valid_i/in_stall_o   req_type, in_year, in_month, in_day, amount
// out      source     out_valid_o/out_stall_i out_year, out_month, out_day, weekday,
//                                             day_of_year, is_leap, overflow
//
// One request at a time: the input stalls until the controller is back in idle.
// Add days steps the month walk once per month crossed, so its run time grows with
// the amount; add months takes the same path for every amount.
// Reset: rst_ni asynchronous, active low; clears the controller and the output valid.
// Stalls: a finished result sits in the output register while the next input beat
// is taken; the controller holds in its final state only while that register is full and out_stall_i is high.
module gregorian_date_arithmetic_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             req_type_i,
  input  logic [gda_pkg::YEAR_W-1:0]       in_year_i,
  input  logic [gda_pkg::MONTH_W-1:0]      in_month_i,
  input  logic [gda_pkg::DAY_W-1:0]        in_day_i,
  input  logic signed [gda_pkg::AMT_W-1:0] amount_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gda_pkg::YEAR_W-1:0]       out_year_o,
  output logic [gda_pkg::MONTH_W-1:0]      out_month_o,
  output logic [gda_pkg::DAY_W-1:0]        out_day_o,
  output logic [gda_pkg::WD_W-1:0]         weekday_o,
  output logic [gda_pkg::DOY_W-1:0]        day_of_year_o,
  output logic                             is_leap_o,
  output logic                             overflow_o
);
  import gda_pkg::*;

  // Controller sequences the steps; the datapath holds the date, the month walk,
  // and one shared reciprocal multiplier for the divides by 7, 12, 100 and 400.
  cmd_t cmd;
  sts_t sts;

  gda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Days: walk month by month with a signed day offset from the 1st; leaving
  // 0001-01 or 9999-12 flags overflow and restores the input date.
  // Months: floor divide of the month index by 12, then clamp the day.
  // Weekday uses the full y + y/4 - y/100 + y/400 form.
  gda_datapath u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .in_year_i     (in_year_i),
    .in_month_i    (in_month_i),
    .in_day_i      (in_day_i),
    .amount_i      (amount_i),
    .out_year_o    (out_year_o),
    .out_month_o   (out_month_o),
    .out_day_o     (out_day_o),
    .weekday_o     (weekday_o),
    .day_of_year_o (day_of_year_o),
    .is_leap_o     (is_leap_o),
    .overflow_o    (overflow_o)
  );

endmodule

// File: src/gda_divc.sv
module gda_divc (
  input  logic                        clk_i,
  input  gda_pkg::div_e               sel_i,
  input  logic [gda_pkg::OPND_W-1:0]  opnd_i,
  output logic [gda_pkg::OPND_W-1:0]  quot_o
);
  import gda_pkg::*;

  logic [PROD_W-1:0] prod_q;
  div_e              sel_q;

  // product registered, shift applied on the way out
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(opnd_i) * PROD_W'(div_recip(sel_i));
    sel_q  <= sel_i;
  end

  assign quot_o = OPND_W'(prod_q >> div_shift(sel_q));

endmodule

// File: src/gda_datapath.sv
module gda_datapath (
  input  logic                         clk_i,
  input  gda_pkg::cmd_t                cmd_i,
  output gda_pkg::sts_t                sts_o,
  input  logic                         req_type_i,
  input  logic [gda_pkg::YEAR_W-1:0]   in_year_i,
  input  logic [gda_pkg::MONTH_W-1:0]  in_month_i,
  input  logic [gda_pkg::DAY_W-1:0]    in_day_i,
  input  logic signed [gda_pkg::AMT_W-1:0] amount_i,
  output logic [gda_pkg::YEAR_W-1:0]   out_year_o,
  output logic [gda_pkg::MONTH_W-1:0]  out_month_o,
  output logic [gda_pkg::DAY_W-1:0]    out_day_o,
  output logic [gda_pkg::WD_W-1:0]     weekday_o,
  output logic [gda_pkg::DOY_W-1:0]    day_of_year_o,
  output logic                         is_leap_o,
  output logic                         overflow_o
);
  import gda_pkg::*;

  // latched request
  logic                     op_q;
  logic [YEAR_W-1:0]        iy_q;
  logic [MONTH_W-1:0]       im_q;
  logic [DAY_W-1:0]         id_q;
  logic signed [AMT_W-1:0]  amt_q;
  logic                     bad_q;

  // working date
  logic [YEAR_W-1:0]        cy_q;
  logic [MONTH_W-1:0]       cm_q;
  logic [DAY_W-1:0]         rd_q;
  logic signed [16:0]       r_q;
  logic [YMOD_W-1:0]        ymod_q;
  logic                     ovf_q;
  logic                     leap_q;
  logic [15:0]              s_q;
  logic [WD_W-1:0]          wd_q;
  logic [DOY_W-1:0]         doy_q;

  // result register
  logic [YEAR_W-1:0]        oy_q;
  logic [MONTH_W-1:0]       om_q;
  logic [DAY_W-1:0]         od_q;
  logic [WD_W-1:0]          owd_q;
  logic [DOY_W-1:0]         odoy_q;
  logic                     olp_q;
  logic                     oovf_q;

  div_e                     div_sel;
  logic [OPND_W-1:0]        div_opnd;
  logic [OPND_W-1:0]        quot;

  gda_divc u_divc (
    .clk_i  (clk_i),
    .sel_i  (div_sel),
    .opnd_i (div_opnd),
    .quot_o (quot)
  );

  // month walk
  logic                     leap_c;
  logic [DAY_W-1:0]         len_c;
  logic [MONTH_W-1:0]       pm_c;
  logic [DAY_W-1:0]         len_prev_c;
  logic                     fwd_c;
  logic                     back_c;
  logic                     at_end_c;
  logic                     at_start_c;

  assign leap_c     = leap_of_mod(ymod_q);
  assign len_c      = month_len(cm_q, leap_c);
  assign pm_c       = (cm_q == MONTH_JAN) ? MONTH_DEC : cm_q - 4'd1;
  assign len_prev_c = month_len(pm_c, leap_c);   // Dec before Jan is 31 either way
  assign fwd_c      = r_q >= $signed({12'd0, len_c});
  assign back_c     = r_q[16];
  assign at_end_c   = (cy_q == YEAR_MAX) && (cm_q == MONTH_DEC);
  assign at_start_c = (cy_q == YEAR_MIN) && (cm_q == MONTH_JAN);

  // month add: month index split by 12
  logic signed [17:0]       mx_c;
  logic [OPND_W-1:0]        mag_c;
  logic signed [13:0]       qs_c;
  logic signed [17:0]       rem_c;
  logic signed [15:0]       ty_c;
  logic                     ty_bad_c;

  assign mx_c  = $signed({14'd0, im_q}) - 18'sd1 + $signed({{2{amt_q[15]}}, amt_q});
  assign mag_c = mx_c[17] ? OPND_W'(18'sd11 - mx_c) : mx_c[16:0];
  assign qs_c  = mx_c[17] ? -$signed({2'b00, quot[11:0]}) : $signed({2'b00, quot[11:0]});
  assign rem_c = mx_c - $signed({{4{qs_c[13]}}, qs_c}) * 18'sd12;
  assign ty_c  = $signed({2'b00, iy_q}) + $signed({{2{qs_c[13]}}, qs_c});
  assign ty_bad_c = (ty_c < $signed({2'b00, YEAR_MIN})) || (ty_c > $signed({2'b00, YEAR_MAX}));

  // year mod 400, weekday year and sum
  logic [YMOD_W-1:0]        ymod_n;
  logic                     leap_n;
  logic [DAY_W-1:0]         ml_n;
  logic [YEAR_W-1:0]        yw_c;
  logic [6:0]               q100_c;
  logic [15:0]              s_c;

  assign ymod_n = YMOD_W'(cy_q - 14'(quot[4:0]) * 14'd400);
  assign leap_n = leap_of_mod(ymod_n);
  assign ml_n   = month_len(cm_q, leap_n);
  assign yw_c   = cy_q - 14'(cm_q < MONTH_MAR);
  assign q100_c = quot[6:0];
  assign s_c    = 16'(rd_q) + 16'(wd_month_term(cm_q)) + 16'(yw_c) + 16'(yw_c >> 2)
                - 16'(q100_c) + 16'(q100_c >> 2) + 16'd1;

  always_comb begin
    case (cmd_i.step)
      DP_DMOD_MUL: begin
        div_sel  = DIV_400;
        div_opnd = OPND_W'(iy_q);
      end
      DP_MDIV_MUL: begin
        div_sel  = DIV_12;
        div_opnd = mag_c;
      end
      DP_CENT_MUL: begin
        div_sel  = DIV_100;
        div_opnd = OPND_W'(yw_c);
      end
      DP_WD_MUL: begin
        div_sel  = DIV_7;
        div_opnd = OPND_W'(s_q);
      end
      default: begin
        div_sel  = DIV_400;
        div_opnd = OPND_W'(cy_q);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.step)
      DP_LOAD: begin
        op_q   <= req_type_i;
        iy_q   <= in_year_i;
        im_q   <= in_month_i;
        id_q   <= in_day_i;
        amt_q  <= amount_i;
        bad_q  <= (in_year_i < YEAR_MIN) || (in_year_i > YEAR_MAX) ||
                  (in_month_i < MONTH_JAN) || (in_month_i > MONTH_DEC);
        cy_q   <= in_year_i;
        cm_q   <= in_month_i;
        rd_q   <= in_day_i;
        ovf_q  <= 1'b0;
        // days past the first of the start month
        r_q    <= $signed({12'd0, in_day_i}) - 17'sd1 + $signed({amount_i[15], amount_i});
      end
      DP_DMOD_SUB: begin
        ymod_q <= ymod_n;
      end
      DP_WALK: begin
        if (fwd_c) begin
          if (at_end_c) begin
            ovf_q <= 1'b1;
            cy_q  <= iy_q;
            cm_q  <= im_q;
            rd_q  <= id_q;
          end else begin
            r_q <= r_q - $signed({12'd0, len_c});
            if (cm_q == MONTH_DEC) begin
              cm_q   <= MONTH_JAN;
              cy_q   <= cy_q + 14'd1;
              ymod_q <= (ymod_q == YMOD_MAX) ? '0 : ymod_q + 9'd1;
            end else begin
              cm_q <= cm_q + 4'd1;
            end
          end
        end else if (back_c) begin
          if (at_start_c) begin
            ovf_q <= 1'b1;
            cy_q  <= iy_q;
            cm_q  <= im_q;
            rd_q  <= id_q;
          end else begin
            r_q  <= r_q + $signed({12'd0, len_prev_c});
            cm_q <= pm_c;
            if (cm_q == MONTH_JAN) begin
              cy_q   <= cy_q - 14'd1;
              ymod_q <= (ymod_q == '0) ? YMOD_MAX : ymod_q - 9'd1;
            end
          end
        end else begin
          rd_q <= r_q[4:0] + 5'd1;
        end
      end
      DP_MDIV_SUB: begin
        if (ty_bad_c) begin
          ovf_q <= 1'b1;
        end else begin
          cy_q <= ty_c[13:0];
          cm_q <= rem_c[3:0] + 4'd1;
        end
      end
      DP_YMOD_SUB: begin
        ymod_q <= ymod_n;
        leap_q <= leap_n;
        // month add clamps the day into the target month
        if (op_q == OP_ADD_MONTHS && !ovf_q) begin
          if (id_q == '0) begin
            rd_q <= 5'd1;
          end else if (id_q > ml_n) begin
            rd_q <= ml_n;
          end else begin
            rd_q <= id_q;
          end
        end
      end
      DP_CENT_SUM: begin
        s_q   <= s_c;
        doy_q <= month_cum(cm_q) + 9'(rd_q) + 9'((cm_q > MONTH_FEB) && leap_q);
      end
      DP_WD_SUB: begin
        wd_q <= WD_W'(s_q - 16'(quot) * 16'd7);
      end
      default: begin
      end
    endcase

    if (cmd_i.load_out) begin
      oy_q   <= cy_q;
      om_q   <= cm_q;
      od_q   <= rd_q;
      owd_q  <= bad_q ? '0 : wd_q;
      odoy_q <= bad_q ? '0 : doy_q;
      olp_q  <= bad_q ? 1'b0 : leap_q;
      oovf_q <= ovf_q | bad_q;
    end
  end

  assign sts_o.bad       = bad_q;
  assign sts_o.months    = (op_q == OP_ADD_MONTHS);
  assign sts_o.walk_done = (!fwd_c && !back_c) || (fwd_c && at_end_c) || (back_c && at_start_c);

  assign out_year_o    = oy_q;
  assign out_month_o   = om_q;
  assign out_day_o     = od_q;
  assign weekday_o     = owd_q;
  assign day_of_year_o = odoy_q;
  assign is_leap_o     = olp_q;
  assign overflow_o    = oovf_q;

endmodule

// File: src/gda_ctrl.sv
module gda_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  gda_pkg::sts_t  sts_i,
  output gda_pkg::cmd_t  cmd_o
);
  import gda_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (accept) state_d = ST_START;
      ST_START: begin
        if (sts_i.bad) begin
          state_d = ST_OUT;
        end else if (sts_i.months) begin
          state_d = ST_MDIV_MUL;
        end else begin
          state_d = ST_DMOD_MUL;
        end
      end
      ST_DMOD_MUL: state_d = ST_DMOD_SUB;
      ST_DMOD_SUB: state_d = ST_WALK;
      ST_WALK:     if (sts_i.walk_done) state_d = ST_YMOD_MUL;
      ST_MDIV_MUL: state_d = ST_MDIV_SUB;
      ST_MDIV_SUB: state_d = ST_YMOD_MUL;
      ST_YMOD_MUL: state_d = ST_YMOD_SUB;
      ST_YMOD_SUB: state_d = ST_CENT_MUL;
      ST_CENT_MUL: state_d = ST_CENT_SUM;
      ST_CENT_SUM: state_d = ST_WD_MUL;
      ST_WD_MUL:   state_d = ST_WD_SUB;
      ST_WD_SUB:   state_d = ST_OUT;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.load_out = 1'b0;
    case (state_q)
      ST_IDLE:     cmd_o.step = accept ? DP_LOAD : DP_NOP;
      ST_DMOD_MUL: cmd_o.step = DP_DMOD_MUL;
      ST_DMOD_SUB: cmd_o.step = DP_DMOD_SUB;
      ST_WALK:     cmd_o.step = DP_WALK;
      ST_MDIV_MUL: cmd_o.step = DP_MDIV_MUL;
      ST_MDIV_SUB: cmd_o.step = DP_MDIV_SUB;
      ST_YMOD_MUL: cmd_o.step = DP_YMOD_MUL;
      ST_YMOD_SUB: cmd_o.step = DP_YMOD_SUB;
      ST_CENT_MUL: cmd_o.step = DP_CENT_MUL;
      ST_CENT_SUM: cmd_o.step = DP_CENT_SUM;
      ST_WD_MUL:   cmd_o.step = DP_WD_MUL;
      ST_WD_SUB:   cmd_o.step = DP_WD_SUB;
      ST_OUT: begin
        cmd_o.step     = DP_NOP;
        cmd_o.load_out = out_free;
      end
      default:     cmd_o.step = DP_NOP;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
